// ===== sv/round_robin_thread_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Clocked checks used by the scheduler datapath.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// check an implication on every clock edge outside reset
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check an invariant on every clock edge outside reset
`define RRTS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// ===== sv/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduler package
// Widths, command and status codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int ID_W      = 3;
    localparam int CNT_W     = 4;
    localparam int TICK_W    = 32;

    localparam logic [2:0] CMD_CREATE    = 3'd0;
    localparam logic [2:0] CMD_KILL_RUN  = 3'd1;
    localparam logic [2:0] CMD_SLEEP_RUN = 3'd2;
    localparam logic [2:0] CMD_KILL_ID   = 3'd3;
    localparam logic [2:0] CMD_SLEEP_ID  = 3'd4;
    localparam logic [2:0] CMD_TICK      = 3'd5;
    localparam logic [2:0] CMD_SWITCH    = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POOL_EMPTY = 2'd1;
    localparam logic [1:0] ST_RING_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOT_READY  = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CREATE,
        OP_FAIL,
        OP_REMOVE,
        OP_TICK_INIT,
        OP_TICK_STEP,
        OP_TICK_END,
        OP_SWITCH,
        OP_SELF,
        OP_LINK1,
        OP_LINK2,
        OP_LINK3,
        OP_LINK4,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] fail_status;
        logic       hold;
    } t_ctrl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       no_free;
        logic       ring_empty;
        logic       x_in_ring;
        logic       tick_end;
        logic       wake_now;
        logic       out_full;
    } t_stat;

endpackage

// ===== sv/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences decode, unlink, ring insertion and the sleeper walk.
// ----------------------------------------------------------------------------
module rrts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rrts_pkg::t_stat i_stat,
    output rrts_pkg::t_ctrl o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_TICK, S_SELF, S_LINK1, S_LINK2, S_LINK3, S_LINK4, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic          r_ret_tick, n_ret_tick;
    logic          r_hold, n_hold;
    rrts_pkg::t_op op;
    logic [1:0]    fail_st;
    t_state        ret_state;

    always_comb begin
        ret_state  = r_ret_tick ? S_TICK : S_DONE;
        n_state    = r_state;
        n_ret_tick = r_ret_tick;
        n_hold     = r_hold;
        op         = rrts_pkg::OP_NONE;
        fail_st    = rrts_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                    n_hold  = 1'b1;
                end
            end
            S_DEC: begin
                n_state = S_DONE;
                unique case (i_stat.cmd) inside
                    rrts_pkg::CMD_CREATE: begin
                        if (i_stat.no_free) begin
                            op      = rrts_pkg::OP_FAIL;
                            fail_st = rrts_pkg::ST_POOL_EMPTY;
                        end else begin
                            op         = rrts_pkg::OP_CREATE;
                            n_state    = S_SELF;
                            n_ret_tick = 1'b0;
                        end
                    end
                    rrts_pkg::CMD_KILL_RUN, rrts_pkg::CMD_SLEEP_RUN: begin
                        if (i_stat.ring_empty) begin
                            op      = rrts_pkg::OP_FAIL;
                            fail_st = rrts_pkg::ST_RING_EMPTY;
                        end else if (!i_stat.x_in_ring) begin
                            op      = rrts_pkg::OP_FAIL;
                            fail_st = rrts_pkg::ST_NOT_READY;
                        end else begin
                            op = rrts_pkg::OP_REMOVE;
                        end
                    end
                    rrts_pkg::CMD_KILL_ID, rrts_pkg::CMD_SLEEP_ID: begin
                        if (!i_stat.x_in_ring) begin
                            op      = rrts_pkg::OP_FAIL;
                            fail_st = rrts_pkg::ST_NOT_READY;
                        end else begin
                            op = rrts_pkg::OP_REMOVE;
                        end
                    end
                    rrts_pkg::CMD_TICK: begin
                        op      = rrts_pkg::OP_TICK_INIT;
                        n_state = S_TICK;
                    end
                    rrts_pkg::CMD_SWITCH: op = rrts_pkg::OP_SWITCH;
                    default: op = rrts_pkg::OP_NONE;
                endcase
            end
            S_TICK: begin
                if (i_stat.tick_end) begin
                    op      = rrts_pkg::OP_TICK_END;
                    n_state = S_DONE;
                end else begin
                    op = rrts_pkg::OP_TICK_STEP;
                    if (i_stat.wake_now) begin
                        n_state    = S_SELF;
                        n_ret_tick = 1'b1;
                    end
                end
            end
            S_SELF: begin
                op      = rrts_pkg::OP_SELF;
                n_state = S_LINK1;
            end
            S_LINK1: begin
                op      = rrts_pkg::OP_LINK1;
                n_state = i_stat.ring_empty ? ret_state : S_LINK2;
            end
            S_LINK2: begin
                op      = rrts_pkg::OP_LINK2;
                n_state = S_LINK3;
            end
            S_LINK3: begin
                op      = rrts_pkg::OP_LINK3;
                n_state = S_LINK4;
            end
            S_LINK4: begin
                op      = rrts_pkg::OP_LINK4;
                n_state = ret_state;
            end
            S_DONE: begin
                if (!i_stat.out_full) begin
                    op      = rrts_pkg::OP_PUBLISH;
                    n_state = S_IDLE;
                    n_hold  = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret_tick <= 1'b0;
            r_hold     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret_tick <= n_ret_tick;
            r_hold     <= n_hold;
        end
    end

    assign o_ctrl.op          = op;
    assign o_ctrl.fail_status = fail_st;
    assign o_ctrl.hold        = r_hold;

endmodule

// ===== sv/rrts_datapath.sv =====
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready ring links, slot pool, sleeper queue and the result register.
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_macros.svh"

module rrts_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rrts_pkg::t_ctrl i_ctrl,
    output rrts_pkg::t_stat o_stat,
    input  logic [2:0]      i_command,
    input  logic [2:0]      i_target_id,
    input  logic [31:0]     i_sleep_ticks,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [1:0]      o_status,
    output logic [2:0]      o_new_id,
    output logic [2:0]      o_running_id,
    output logic [2:0]      o_ready_total,
    output logic [2:0]      o_free_total,
    output logic [2:0]      o_woken_total
);

    localparam int N   = rrts_pkg::NUM_SLOTS;
    localparam int IW  = rrts_pkg::ID_W;
    localparam int CW  = rrts_pkg::CNT_W;
    localparam int TW  = rrts_pkg::TICK_W;

    logic [IW-1:0] r_nxt [N];
    logic [IW-1:0] r_prv [N];
    logic [TW-1:0] r_rem [N];
    logic [IW-1:0] r_q   [N];
    logic [N-1:0]  r_used, r_sleep;
    logic [CW-1:0] r_qcnt, r_idx, r_kept;
    logic [IW-1:0] r_rcnt, r_run, r_head, r_node, r_a, r_t, r_p;
    logic [2:0]    r_cmd;
    logic [IW-1:0] r_tgt;
    logic [TW-1:0] r_ticks;
    logic [1:0]    r_status;
    logic [IW-1:0] r_new, r_woken;
    logic          r_out_valid;
    logic [1:0]    r_o_status;
    logic [IW-1:0] r_o_new, r_o_run, r_o_ready, r_o_free, r_o_woken;

    logic [IW-1:0] x_sel, free_slot, s_cur;
    logic [CW-1:0] free_cnt;
    logic          no_free, x_in_ring, wake, is_sleep, is_kill;

    always_comb begin
        is_sleep = (r_cmd == rrts_pkg::CMD_SLEEP_RUN) || (r_cmd == rrts_pkg::CMD_SLEEP_ID);
        is_kill  = (r_cmd == rrts_pkg::CMD_KILL_RUN) || (r_cmd == rrts_pkg::CMD_KILL_ID);
        x_sel    = ((r_cmd == rrts_pkg::CMD_KILL_RUN) || (r_cmd == rrts_pkg::CMD_SLEEP_RUN))
                   ? r_run : r_tgt;
        x_in_ring = (x_sel != '0) && r_used[x_sel] && !r_sleep[x_sel];
        free_slot = '0;
        for (int i = N-1; i >= 1; i--) begin
            if (!r_used[i]) free_slot = IW'(i);
        end
        no_free  = (free_slot == '0);
        free_cnt = '0;
        for (int i = 0; i < N; i++) begin
            free_cnt = free_cnt + CW'(!r_used[i]);
        end
        s_cur = r_q[r_idx[IW-1:0]];
        wake  = (r_rem[s_cur] <= TW'(1));
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.no_free    = no_free;
    assign o_stat.ring_empty = (r_rcnt == '0);
    assign o_stat.x_in_ring  = x_in_ring;
    assign o_stat.tick_end   = (r_idx == r_qcnt);
    assign o_stat.wake_now   = wake;
    assign o_stat.out_full   = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_nxt[i] <= IW'(i);
                r_prv[i] <= IW'(i);
            end
            r_used      <= N'(1);
            r_sleep     <= '0;
            r_qcnt      <= '0;
            r_rcnt      <= '0;
            r_run       <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_ctrl.op == rrts_pkg::OP_PUBLISH) || (r_out_valid && i_out_stall);
            case (i_ctrl.op)
                rrts_pkg::OP_CREATE: begin
                    r_used[free_slot] <= 1'b1;
                    r_node            <= free_slot;
                end
                rrts_pkg::OP_SELF: begin
                    r_nxt[r_node] <= r_node;
                    r_prv[r_node] <= r_node;
                end
                rrts_pkg::OP_LINK1: begin
                    if (r_rcnt == '0) begin
                        r_head       <= r_node;
                        r_nxt[r_run] <= r_node;
                        r_prv[r_run] <= r_node;
                        r_rcnt       <= r_rcnt + IW'(1);
                    end else begin
                        r_a <= r_nxt[r_run];
                    end
                end
                rrts_pkg::OP_LINK2: r_t <= r_prv[r_a];
                rrts_pkg::OP_LINK3: r_p <= r_prv[r_t];
                rrts_pkg::OP_LINK4: begin
                    r_nxt[r_node] <= r_t;
                    r_prv[r_node] <= r_p;
                    r_prv[r_t]    <= r_node;
                    r_nxt[r_p]    <= r_node;
                    r_rcnt        <= r_rcnt + IW'(1);
                end
                rrts_pkg::OP_REMOVE: begin
                    if (r_rcnt > IW'(1)) begin
                        r_nxt[r_prv[x_sel]] <= r_nxt[x_sel];
                        r_prv[r_nxt[x_sel]] <= r_prv[x_sel];
                        if (x_sel == r_head) r_head <= r_nxt[x_sel];
                    end else begin
                        r_nxt[r_run] <= '0;
                        r_nxt[0]     <= '0;
                        r_prv[0]     <= '0;
                        r_nxt[x_sel] <= '0;
                        r_head       <= '0;
                    end
                    r_rcnt <= r_rcnt - IW'(1);
                    if (is_kill) r_used[x_sel] <= 1'b0;
                    if (is_sleep) begin
                        r_sleep[x_sel] <= 1'b1;
                        if (r_qcnt < CW'(N)) r_qcnt <= r_qcnt + CW'(1);
                    end
                end
                rrts_pkg::OP_TICK_INIT: begin
                    r_idx  <= '0;
                    r_kept <= '0;
                end
                rrts_pkg::OP_TICK_STEP: begin
                    r_idx <= r_idx + CW'(1);
                    if (wake) begin
                        r_sleep[s_cur] <= 1'b0;
                        r_node         <= s_cur;
                    end else begin
                        r_kept <= r_kept + CW'(1);
                    end
                end
                rrts_pkg::OP_TICK_END: r_qcnt <= r_kept;
                rrts_pkg::OP_SWITCH:   r_run  <= r_nxt[r_run];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctrl.hold) begin
            r_cmd    <= i_command;
            r_tgt    <= i_target_id;
            r_ticks  <= i_sleep_ticks;
            r_status <= rrts_pkg::ST_OK;
            r_new    <= '0;
            r_woken  <= '0;
        end
        case (i_ctrl.op)
            rrts_pkg::OP_FAIL:   r_status <= i_ctrl.fail_status;
            rrts_pkg::OP_CREATE: r_new    <= free_slot;
            rrts_pkg::OP_REMOVE: begin
                if (is_sleep) begin
                    r_rem[x_sel] <= r_ticks;
                    if (r_qcnt < CW'(N)) r_q[r_qcnt[IW-1:0]] <= x_sel;
                end
            end
            rrts_pkg::OP_TICK_STEP: begin
                if (wake) begin
                    r_rem[s_cur] <= '0;
                    r_woken      <= r_woken + IW'(1);
                end else begin
                    r_rem[s_cur]           <= r_rem[s_cur] - TW'(1);
                    r_q[r_kept[IW-1:0]]    <= s_cur;
                end
            end
            rrts_pkg::OP_PUBLISH: begin
                r_o_status <= r_status;
                r_o_new    <= r_new;
                r_o_run    <= r_run;
                r_o_ready  <= r_rcnt;
                r_o_free   <= free_cnt[IW-1:0];
                r_o_woken  <= r_woken;
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_new_id      = r_o_new;
    assign o_running_id  = r_o_run;
    assign o_ready_total = r_o_ready;
    assign o_free_total  = r_o_free;
    assign o_woken_total = r_o_woken;

    `RRTS_ASSERT_ALWAYS(a_idle_used, r_used[0], "idle slot released")
    `RRTS_ASSERT_IMP(a_empty_head, r_rcnt == '0, r_head == '0, "empty ring with live head")
    `RRTS_ASSERT_ALWAYS(a_sleep_used, (r_sleep & ~r_used) == '0, "sleeper in free slot")
    `RRTS_ASSERT_IMP(a_qcnt_sleep, i_ctrl.hold == 1'b0, r_qcnt == CW'($countones(r_sleep)),
        "sleeper count out of step")

endmodule

// ===== sv/round_robin_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Ready ring of threads with a FIFO of sleepers counted down by ticks.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | word
//  input    | in        | i_in_valid / o_in_stall    | command, target_id, sleep_ticks
//  output   | out       | o_out_valid / i_out_stall  | status, new_id, running_id, totals
//
//  One command at a time: decode, then done; create goes through the self-link
//  and LINK1 to LINK4 (LINK1 only into an empty ring), tick walks each sleeper
//  and re-links each woken thread alike; ring insertion uses the link registers.
//  A finished word waits in the output register; the next command is taken
//  meanwhile and holds in its last cycle until that register frees.
//  Synchronous active-low reset; ready ring empty, only the idle slot in use.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_target_id,
    input  logic [31:0] i_sleep_ticks,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_new_id,
    output logic [2:0]  o_running_id,
    output logic [2:0]  o_ready_total,
    output logic [2:0]  o_free_total,
    output logic [2:0]  o_woken_total
);

    rrts_pkg::t_ctrl ctrl;
    rrts_pkg::t_stat stat;

    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    rrts_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_target_id   (i_target_id),
        .i_sleep_ticks (i_sleep_ticks),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_new_id      (o_new_id),
        .o_running_id  (o_running_id),
        .o_ready_total (o_ready_total),
        .o_free_total  (o_free_total),
        .o_woken_total (o_woken_total)
    );

    assign o_in_stall = ctrl.hold;

endmodule
